FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL. Empty when synthesising.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SBI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SBI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SBI_ASSERT(label, clk, rst_n, prop, msg)
`define SBI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/sbi_pkg.sv
// ----------------------------------------------------------------------------
// sbi_pkg
// Widths, constants and controller/datapath interface types of the
// spatial balance index block.
// ----------------------------------------------------------------------------
package sbi_pkg;

    localparam int MAX_SAMPLE = 64;
    localparam int SLOT_W     = 6;
    localparam int CNT_W      = 7;
    localparam int DIST_W     = 16;
    localparam int PROB_W     = 17;
    localparam int SUM_W      = 32;
    localparam int ACC_W      = 38;
    localparam int SQ_W       = 64;
    localparam int SQACC_W    = 70;
    localparam int HI_W       = ACC_W - SUM_W;
    localparam int NSQ_W      = 76;
    localparam int FRAC_DROP  = 16;
    localparam int DIV_W      = NSQ_W - FRAC_DROP;
    localparam int DIV_CNT_W  = 6;
    localparam int M_W        = 13;
    localparam int OUT_W      = 48;

    localparam logic [CNT_W-1:0]  MAX_COUNT = CNT_W'(MAX_SAMPLE);
    localparam logic [PROB_W-1:0] PROB_ONE  = PROB_W'(65536);
    localparam logic [DIST_W-1:0] DIST_MAX  = '1;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIV_W);

    typedef struct packed {
        logic accept;
        logic idx_clr;
        logic idx_inc;
        logic tie_rd;
        logic tie_wr;
        logic tie_done;
        logic acc_clr;
        logic var_rd;
        logic var_sq;
        logic var_add;
        logic fin1;
        logic fin2;
        logic fin3;
        logic div_step;
        logic out_load;
        logic out_zero;
    } sbi_cmd_t;

    typedef struct packed {
        logic item_end;
        logic pop_end;
        logic walk_end;
        logic n_small;
        logic div_done;
        logic out_taken;
    } sbi_status_t;

endpackage

FILE: rtl/sbi_ctrl.sv
// ----------------------------------------------------------------------------
// sbi_ctrl
// Sequencer: accepts beats, walks the slot store for the tie update and the
// variance sums, then runs the final arithmetic and the divider.
// ----------------------------------------------------------------------------
module sbi_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  sbi_pkg::sbi_status_t status,
    output sbi_pkg::sbi_cmd_t    cmd
);

    typedef enum logic [10:0] {
        ST_IDLE    = 11'b00000000001,
        ST_TIE_RD  = 11'b00000000010,
        ST_TIE_WR  = 11'b00000000100,
        ST_VAR_RD  = 11'b00000001000,
        ST_VAR_SQ  = 11'b00000010000,
        ST_VAR_ADD = 11'b00000100000,
        ST_FIN1    = 11'b00001000000,
        ST_FIN2    = 11'b00010000000,
        ST_FIN3    = 11'b00100000000,
        ST_DIV     = 11'b01000000000,
        ST_OUT     = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.item_end)
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = ST_TIE_RD;
                    end
                end
            end
            ST_TIE_RD:
            begin
                if (status.walk_end)
                begin
                    cmd.tie_done = 1'b1;
                    if (!status.pop_end)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (status.n_small)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_zero = 1'b1;
                        state_next   = ST_OUT;
                    end
                    else
                    begin
                        cmd.idx_clr = 1'b1;
                        cmd.acc_clr = 1'b1;
                        state_next  = ST_VAR_RD;
                    end
                end
                else
                begin
                    cmd.tie_rd = 1'b1;
                    state_next = ST_TIE_WR;
                end
            end
            ST_TIE_WR:
            begin
                cmd.tie_wr  = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = ST_TIE_RD;
            end
            ST_VAR_RD:
            begin
                if (status.walk_end)
                begin
                    state_next = ST_FIN1;
                end
                else
                begin
                    cmd.var_rd = 1'b1;
                    state_next = ST_VAR_SQ;
                end
            end
            ST_VAR_SQ:
            begin
                cmd.var_sq = 1'b1;
                state_next = ST_VAR_ADD;
            end
            ST_VAR_ADD:
            begin
                cmd.var_add = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = ST_VAR_RD;
            end
            ST_FIN1:
            begin
                cmd.fin1   = 1'b1;
                state_next = ST_FIN2;
            end
            ST_FIN2:
            begin
                cmd.fin2   = 1'b1;
                state_next = ST_FIN3;
            end
            ST_FIN3:
            begin
                cmd.fin3   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_OUT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_OUT:
            begin
                if (status.out_taken)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/sbi_dp.sv
// ----------------------------------------------------------------------------
// sbi_dp
// Datapath: running minimum and tie mask, slot accumulator store, variance
// sums, final products, restoring divider and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbi_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_count_we,
    input  logic [sbi_pkg::CNT_W-1:0]           sample_count_wdata,
    input  logic [sbi_pkg::DIST_W-1:0]          distance,
    input  logic [sbi_pkg::SLOT_W-1:0]          sample_slot,
    input  logic [sbi_pkg::PROB_W-1:0]          inclusion_prob,
    input  logic                                unit_done,
    input  logic                                population_done,
    input  sbi_pkg::sbi_cmd_t                   cmd,
    output sbi_pkg::sbi_status_t                status,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [sbi_pkg::OUT_W-1:0]           balance_index
);

    logic [sbi_pkg::CNT_W-1:0]      count_reg;
    logic [sbi_pkg::CNT_W-1:0]      n_eff;
    logic [sbi_pkg::CNT_W-1:0]      idx_reg;
    logic [sbi_pkg::DIST_W-1:0]     min_reg;
    logic [sbi_pkg::MAX_SAMPLE-1:0] tie_reg;
    logic [sbi_pkg::MAX_SAMPLE-1:0] vld_reg;
    logic [sbi_pkg::PROB_W-1:0]     prob_reg;
    logic                           pop_reg;
    logic [sbi_pkg::SUM_W-1:0]      mem [sbi_pkg::MAX_SAMPLE];
    logic [sbi_pkg::SUM_W-1:0]      rd_reg;
    logic                           rd_vld_reg;
    logic [sbi_pkg::SUM_W-1:0]      rd_val;
    logic [sbi_pkg::SUM_W:0]        sat_sum;
    logic [sbi_pkg::SUM_W-1:0]      wr_val;
    logic [sbi_pkg::SLOT_W-1:0]     idx;
    logic [sbi_pkg::ACC_W-1:0]      sum_reg;
    logic [sbi_pkg::SQ_W-1:0]       sq_reg;
    logic [sbi_pkg::SQACC_W-1:0]    sumsq_reg;
    logic [sbi_pkg::SQ_W-1:0]       lolo_reg;
    logic [sbi_pkg::ACC_W-1:0]      hilo_reg;
    logic [sbi_pkg::NSQ_W-1:0]      nsq_reg;
    logic [sbi_pkg::NSQ_W-1:0]      sqt_reg;
    logic [sbi_pkg::M_W-1:0]        m_reg;
    logic [sbi_pkg::NSQ_W-1:0]      diff;
    logic [sbi_pkg::DIV_W-1:0]      quo_reg;
    logic [sbi_pkg::M_W-1:0]        rem_reg;
    logic [sbi_pkg::DIV_CNT_W-1:0]  div_cnt_reg;
    logic [sbi_pkg::M_W:0]          trial;
    logic                           trial_ge;
    logic [sbi_pkg::HI_W-1:0]       sum_hi;
    logic [sbi_pkg::SUM_W-1:0]      sum_lo;
    logic [sbi_pkg::OUT_W-1:0]      out_val;
    logic                           slot_ok;

    assign n_eff    = (count_reg > sbi_pkg::MAX_COUNT) ? sbi_pkg::MAX_COUNT : count_reg;
    assign idx      = idx_reg[sbi_pkg::SLOT_W-1:0];
    assign slot_ok  = {1'b0, sample_slot} < n_eff;
    assign rd_val   = rd_vld_reg ? rd_reg : '0;
    assign sat_sum  = {1'b0, rd_val} + (sbi_pkg::SUM_W+1)'(prob_reg);
    assign wr_val   = sat_sum[sbi_pkg::SUM_W] ? '1 : sat_sum[sbi_pkg::SUM_W-1:0];
    assign sum_hi   = sum_reg[sbi_pkg::ACC_W-1:sbi_pkg::SUM_W];
    assign sum_lo   = sum_reg[sbi_pkg::SUM_W-1:0];
    assign diff     = nsq_reg - sqt_reg;
    assign trial    = {rem_reg, quo_reg[sbi_pkg::DIV_W-1]};
    assign trial_ge = trial >= {1'b0, m_reg};
    assign out_val  = (|quo_reg[sbi_pkg::DIV_W-1:sbi_pkg::OUT_W]) ? '1
                                                                 : quo_reg[sbi_pkg::OUT_W-1:0];

    assign status.item_end  = unit_done | population_done;
    assign status.pop_end   = pop_reg;
    assign status.walk_end  = idx_reg >= n_eff;
    assign status.n_small   = n_eff < sbi_pkg::CNT_W'(2);
    assign status.div_done  = div_cnt_reg == sbi_pkg::DIV_STEPS;
    assign status.out_taken = result_valid & ~result_stall;

    // Control state: register, walk index, minimum, tie mask, entry valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= sbi_pkg::CNT_W'(1);
            idx_reg      <= '0;
            min_reg      <= sbi_pkg::DIST_MAX;
            tie_reg      <= '0;
            vld_reg      <= '0;
            pop_reg      <= 1'b0;
            div_cnt_reg  <= '0;
            result_valid <= 1'b0;
        end
        else
        begin
            if (sample_count_we)
            begin
                count_reg <= sample_count_wdata;
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + sbi_pkg::CNT_W'(1);
            end
            if (cmd.accept)
            begin
                pop_reg <= population_done;
                if (slot_ok)
                begin
                    if (distance < min_reg)
                    begin
                        min_reg <= distance;
                        tie_reg <= sbi_pkg::MAX_SAMPLE'(1) << sample_slot;
                    end
                    else if (distance == min_reg)
                    begin
                        tie_reg[sample_slot] <= 1'b1;
                    end
                end
            end
            if (cmd.tie_done)
            begin
                min_reg <= sbi_pkg::DIST_MAX;
                tie_reg <= '0;
            end
            // A slot that has never been written since the last clear reads as zero.
            if (cmd.out_load)
            begin
                vld_reg <= '0;
            end
            else if (cmd.tie_wr && tie_reg[idx])
            begin
                vld_reg[idx] <= 1'b1;
            end
            if (cmd.fin3)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + sbi_pkg::DIV_CNT_W'(1);
            end
            if (cmd.out_load)
            begin
                result_valid <= 1'b1;
            end
            else if (status.out_taken)
            begin
                result_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tie_wr && tie_reg[idx])
        begin
            mem[idx] <= wr_val;
        end
        if (cmd.tie_rd || cmd.var_rd)
        begin
            rd_reg     <= mem[idx];
            rd_vld_reg <= vld_reg[idx];
        end
    end

    // Payload registers of the arithmetic.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            prob_reg <= (inclusion_prob > sbi_pkg::PROB_ONE) ? sbi_pkg::PROB_ONE
                                                              : inclusion_prob;
        end
        if (cmd.acc_clr)
        begin
            sum_reg   <= '0;
            sumsq_reg <= '0;
        end
        if (cmd.var_sq)
        begin
            sq_reg  <= sbi_pkg::SQ_W'(rd_val) * sbi_pkg::SQ_W'(rd_val);
            sum_reg <= sum_reg + sbi_pkg::ACC_W'(rd_val);
        end
        if (cmd.var_add)
        begin
            sumsq_reg <= sumsq_reg + sbi_pkg::SQACC_W'(sq_reg);
        end
        if (cmd.fin1)
        begin
            lolo_reg <= sbi_pkg::SQ_W'(sum_lo) * sbi_pkg::SQ_W'(sum_lo);
            hilo_reg <= sbi_pkg::ACC_W'(sum_hi) * sbi_pkg::ACC_W'(sum_lo);
            nsq_reg  <= sbi_pkg::NSQ_W'(sumsq_reg) * sbi_pkg::NSQ_W'(n_eff);
            m_reg    <= sbi_pkg::M_W'(n_eff) * (sbi_pkg::M_W'(n_eff) - sbi_pkg::M_W'(1));
        end
        // Square of the total, built from a low and a high part.
        if (cmd.fin2)
        begin
            sqt_reg <= sbi_pkg::NSQ_W'(lolo_reg)
                     + (sbi_pkg::NSQ_W'(hilo_reg) << (sbi_pkg::SUM_W + 1))
                     + (sbi_pkg::NSQ_W'(sum_hi * sum_hi) << (2 * sbi_pkg::SUM_W));
        end
        if (cmd.fin3)
        begin
            quo_reg <= diff[sbi_pkg::NSQ_W-1:sbi_pkg::FRAC_DROP];
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? sbi_pkg::M_W'(trial - {1'b0, m_reg})
                                : trial[sbi_pkg::M_W-1:0];
            quo_reg <= {quo_reg[sbi_pkg::DIV_W-2:0], trial_ge};
        end
        if (cmd.out_load)
        begin
            balance_index <= cmd.out_zero ? '0 : out_val;
        end
    end

    `SBI_ASSERT(a_div_cnt_range, clk, rst_n, div_cnt_reg <= sbi_pkg::DIV_STEPS, "divider overran")
    `SBI_ASSERT(a_div_nonzero, clk, rst_n, !cmd.div_step || m_reg != '0, "divide by zero")
    `SBI_ASSERT(a_tie_idx, clk, rst_n, !cmd.tie_wr || idx_reg < n_eff, "tie write out of range")
    `SBI_ASSERT_NEXT(a_clear_sums, clk, rst_n, cmd.out_load, vld_reg == '0, "sums not cleared")

endmodule

FILE: rtl/spatial_balance_index.sv
// Sequence: an item that does not end a unit is taken while idle; an end of
// unit starts the tie update, a read and a write for each of the n slots in
// use. An end of population adds the sums (read, square, add per slot), the
// products and the restoring divider, then one output beat held until taken;
// with n < 2 the result follows the tie update directly. One item at a time.
// Reset: accumulators read as zero, sample_count is 1, no result pending.
// ----------------------------------------------------------------------------
// spatial_balance_index
// Voronoi spatial balance index: sample variance of the per-slot probability
// sums over the tie sets of the nearest sample units.
// ----------------------------------------------------------------------------
module spatial_balance_index (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_count_we,
    input  logic [sbi_pkg::CNT_W-1:0]         sample_count_wdata,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [sbi_pkg::DIST_W-1:0]        distance,
    input  logic [sbi_pkg::SLOT_W-1:0]        sample_slot,
    input  logic [sbi_pkg::PROB_W-1:0]        inclusion_prob,
    input  logic                              unit_done,
    input  logic                              population_done,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [sbi_pkg::OUT_W-1:0]         balance_index
);

    sbi_pkg::sbi_cmd_t    cmd;
    sbi_pkg::sbi_status_t status;

    sbi_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    sbi_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .sample_count_we    (sample_count_we),
        .sample_count_wdata (sample_count_wdata),
        .distance           (distance),
        .sample_slot        (sample_slot),
        .inclusion_prob     (inclusion_prob),
        .unit_done          (unit_done),
        .population_done    (population_done),
        .cmd                (cmd),
        .status             (status),
        .result_valid       (result_valid),
        .result_stall       (result_stall),
        .balance_index      (balance_index)
    );

endmodule
